>>> rtl/core/power_source_selector_macros.svh
// assertion macros for the power source selector checker
`ifndef POWER_SOURCE_SELECTOR_MACROS_SVH
`define POWER_SOURCE_SELECTOR_MACROS_SVH

// generic clocked assertion with reset disable
`define PSS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("power_source_selector assertion failed");

// a stalled channel keeps valid and the named signal
`define PSS_ASSERT_HOLD(name, clk, rst_n, vld, rdy, sig) \
  `PSS_ASSERT(name, clk, rst_n, (vld && !rdy) |=> (vld && $stable(sig)))

`endif

>>> rtl/core/pss_pkg.sv
// shared types and constants of the power source selector
`timescale 1ns / 1ps
`default_nettype none
package pss_pkg;

  localparam logic [1:0] SRC_PSU  = 2'd0;
  localparam logic [1:0] SRC_BATT = 2'd1;
  localparam logic [1:0] SRC_BOTH = 2'd2;

  localparam logic [1:0] MODE_UNKNOWN = 2'd0;
  localparam logic [1:0] MODE_AUTO    = 2'd1;
  localparam logic [1:0] MODE_BATT    = 2'd2;
  localparam logic [1:0] MODE_PSU     = 2'd3;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_DROP      = 3'd1;
  localparam logic [2:0] EV_MAN_BATT  = 3'd2;
  localparam logic [2:0] EV_MAN_PSU   = 3'd3;
  localparam logic [2:0] EV_AUTO_BATT = 3'd4;
  localparam logic [2:0] EV_AUTO_PSU  = 3'd5;

  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_CHARGED    = 3'd1;
  localparam logic [2:0] REG_LOW        = 3'd2;
  localparam logic [2:0] REG_SENSOR_MIN = 3'd3;
  localparam logic [2:0] REG_SENSOR_MAX = 3'd4;
  localparam logic [2:0] REG_OUT_MIN    = 3'd5;
  localparam logic [2:0] REG_OUT_MAX    = 3'd6;
  localparam logic [2:0] REG_DROP_THR   = 3'd7;

  localparam logic [14:0] DROP_THR_RESET = 15'd9500;
  localparam logic [31:0] HOLDOFF_MS     = 32'd10000;
  localparam logic [31:0] MEASURE_GAP_MS = 32'd10000;
  localparam logic [25:0] LOCAL_MAP_IN   = 26'd1880;
  localparam logic [25:0] LOCAL_MAP_OUT  = 26'd10000;
  localparam int unsigned DIV_BITS       = 34;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        drop;
    logic [15:0] battery_raw;
    logic        battery_valid;
  } item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] charged_mv;
    logic [15:0] low_mv;
    logic [15:0] sensor_min;
    logic [15:0] sensor_max;
    logic [15:0] out_min_mv;
    logic [15:0] out_max_mv;
  } cfg_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_MEAS,
    BS_PREP,
    BS_DIV,
    BS_FIX,
    BS_DECIDE,
    BS_OUT
  } back_state_e;

endpackage
`default_nettype wire

>>> rtl/core/power_source_selector.sv
// power source selector top level: config registers, front, queue and back
// when the battery is measured, an accepted tick passes through pop, multiply, prepare,
//   bit-serial restoring divider, saturate and decide; otherwise it goes from pop to decide
// the back end takes a new tick only after the last result of the previous one is taken;
//   a switch adds two more result transactions
// reset: async active low; source both, battery unknown, no holdoff, queue empty
`timescale 1ns / 1ps
`default_nettype none
module power_source_selector #(
  parameter int unsigned SWITCH_WAIT_MS = 2000
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [11:0] local_raw_mv_i,
  input  wire logic        local_valid_i,
  input  wire logic [15:0] battery_raw_i,
  input  wire logic        battery_valid_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             psu_relay_o,
  output logic             battery_relay_o,
  output logic             psu_led_o,
  output logic             battery_led_o,
  output logic [10:0]      wait_after_ms_o,
  output logic [1:0]       source_o,
  output logic [15:0]      battery_mv_o,
  output logic             battery_known_o,
  output logic [2:0]       event_res_o,
  output logic             last_o
);
  import pss_pkg::*;

  // step hold time, saturated to the field width
  localparam logic [10:0] WaitMs = (SWITCH_WAIT_MS > 2047) ? 11'd2047 : 11'(SWITCH_WAIT_MS);

  cfg_t        cfg_q, cfg_d;
  logic [14:0] thr_q, thr_d;

  item_t front_item, q_item;
  logic  front_vld, q_push_rdy, q_vld, q_pop_rdy;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    thr_d = thr_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:       cfg_d.mode       = cfg_data_i[1:0];
        REG_CHARGED:    cfg_d.charged_mv = cfg_data_i;
        REG_LOW:        cfg_d.low_mv     = cfg_data_i;
        REG_SENSOR_MIN: cfg_d.sensor_min = cfg_data_i;
        REG_SENSOR_MAX: cfg_d.sensor_max = cfg_data_i;
        REG_OUT_MIN:    cfg_d.out_min_mv = cfg_data_i;
        REG_OUT_MAX:    cfg_d.out_max_mv = cfg_data_i;
        REG_DROP_THR:   thr_d            = cfg_data_i[14:0];
        default:        thr_d            = thr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
      thr_q <= DROP_THR_RESET;
    end else begin
      cfg_q <= cfg_d;
      thr_q <= thr_d;
    end
  end

  // front: takes ticks and computes the drop flag
  pss_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .now_ms_i,
    .local_raw_mv_i,
    .local_valid_i,
    .battery_raw_i,
    .battery_valid_i,
    .drop_thr_i   (thr_q),
    .item_o       (front_item),
    .item_valid_o (front_vld),
    .item_ready_i (q_push_rdy)
  );

  // decouples front from the slow back end
  pss_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_item_i  (front_item),
    .push_valid_i (front_vld),
    .push_ready_o (q_push_rdy),
    .pop_item_o   (q_item),
    .pop_valid_o  (q_vld),
    .pop_ready_i  (q_pop_rdy)
  );

  // back: measurement, decision and result sequence
  pss_back #(
    .WaitMs (WaitMs)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .item_i       (q_item),
    .item_valid_i (q_vld),
    .item_ready_o (q_pop_rdy),
    .out_valid_o,
    .out_ready_i,
    .psu_relay_o,
    .battery_relay_o,
    .psu_led_o,
    .battery_led_o,
    .wait_after_ms_o,
    .source_o,
    .battery_mv_o,
    .battery_known_o,
    .event_res_o,
    .last_o
  );
endmodule
`default_nettype wire

>>> rtl/core/pss_front.sv
// front end: takes a tick and classifies the local rail sample
`timescale 1ns / 1ps
`default_nettype none
module pss_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [31:0]   now_ms_i,
  input  wire logic [11:0]   local_raw_mv_i,
  input  wire logic          local_valid_i,
  input  wire logic [15:0]   battery_raw_i,
  input  wire logic          battery_valid_i,
  input  wire logic [14:0]   drop_thr_i,
  output pss_pkg::item_t     item_o,
  output logic               item_valid_o,
  input  wire logic          item_ready_i
);
  import pss_pkg::*;

  logic        vld_q, vld_d;
  item_t       item_q, item_d;
  logic [25:0] lhs, rhs;
  logic        take;

  assign lhs = 26'(local_raw_mv_i) * LOCAL_MAP_OUT;
  assign rhs = 26'(drop_thr_i) * LOCAL_MAP_IN;

  assign in_ready_o   = !vld_q || item_ready_i;
  assign take         = in_valid_i && in_ready_o;
  assign item_o       = item_q;
  assign item_valid_o = vld_q;

  always_comb begin
    vld_d  = vld_q;
    item_d = item_q;
    if (item_ready_i) vld_d = 1'b0;
    if (take) begin
      vld_d                = 1'b1;
      item_d.now_ms        = now_ms_i;
      item_d.drop          = !local_valid_i || (lhs <= rhs);
      item_d.battery_raw   = battery_raw_i;
      item_d.battery_valid = battery_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end
endmodule
`default_nettype wire

>>> rtl/core/pss_queue.sv
// two-entry queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module pss_queue (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  pss_pkg::item_t push_item_i,
  input  wire logic      push_valid_i,
  output logic           push_ready_o,
  output pss_pkg::item_t pop_item_o,
  output logic           pop_valid_o,
  input  wire logic      pop_ready_i
);
  import pss_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_item_i;
  end
endmodule
`default_nettype wire

>>> rtl/core/pss_back.sv
// back end: battery measurement, source decision and relay sequence
`timescale 1ns / 1ps
`default_nettype none
module pss_back #(
  parameter logic [10:0] WaitMs = 11'd2000
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  pss_pkg::cfg_t       cfg_i,
  input  pss_pkg::item_t      item_i,
  input  wire logic           item_valid_i,
  output logic                item_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic                psu_relay_o,
  output logic                battery_relay_o,
  output logic                psu_led_o,
  output logic                battery_led_o,
  output logic [10:0]         wait_after_ms_o,
  output logic [1:0]          source_o,
  output logic [15:0]         battery_mv_o,
  output logic                battery_known_o,
  output logic [2:0]          event_res_o,
  output logic                last_o
);
  import pss_pkg::*;

  back_state_e   st_q, st_d;
  item_t         item_q, item_d;
  logic [1:0]    src_q, src_d, old_q, old_d;
  logic [15:0]   lvl_q, lvl_d;
  logic          known_q, known_d;
  logic [31:0]   meas_q, meas_d, hold_q, hold_d;
  logic          armed_q, armed_d;
  logic signed [33:0] n_q, n_d;
  logic signed [17:0] dv_q, dv_d;
  logic          neg_q, neg_d;
  logic [33:0]   div_q, div_d;
  logic [17:0]   rem_q, rem_d;
  logic [16:0]   den_q, den_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [2:0]    ev_q, ev_d;
  logic          sw_q, sw_d;
  logic [1:0]    step_q, step_d;

  logic               low, charged, meas_en;
  logic [31:0]        next_meas;
  logic signed [16:0] a_op, b_op;
  logic [33:0]        an;
  logic [15:0]        ad;
  logic [17:0]        shifted;
  logic               ge;
  logic [34:0]        sum;
  logic               fin;

  assign low       = !known_q || (cfg_i.low_mv != 16'd0 && lvl_q <= cfg_i.low_mv);
  assign charged   = known_q && cfg_i.charged_mv != 16'd0 && lvl_q >= cfg_i.charged_mv;
  assign meas_en   = cfg_i.sensor_max != 16'd0 && cfg_i.out_max_mv != 16'd0;
  assign next_meas = meas_q + MEASURE_GAP_MS;
  assign a_op      = $signed({1'b0, item_q.battery_raw}) - $signed({1'b0, cfg_i.sensor_min});
  assign b_op      = $signed({1'b0, cfg_i.out_max_mv}) - $signed({1'b0, cfg_i.out_min_mv});
  assign an        = n_q[33] ? 34'(-n_q) : 34'(n_q);
  assign ad        = dv_q[17] ? 16'(-dv_q) : 16'(dv_q);
  assign shifted   = {rem_q[16:0], div_q[33]};
  assign ge        = shifted >= {1'b0, den_q};
  assign sum       = {1'b0, div_q} + 35'(cfg_i.out_min_mv);
  assign fin       = !sw_q || step_q == 2'd2;

  always_comb begin
    st_d = st_q; item_d = item_q; src_d = src_q; old_d = old_q;
    lvl_d = lvl_q; known_d = known_q; meas_d = meas_q; hold_d = hold_q;
    armed_d = armed_q; n_d = n_q; dv_d = dv_q; neg_d = neg_q; div_d = div_q;
    rem_d = rem_q; den_d = den_q; cnt_d = cnt_q; ev_d = ev_q; sw_d = sw_q;
    step_d = step_q;
    item_ready_o = 1'b0;
    case (st_q)
      BS_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          item_d = item_i;
          st_d   = BS_MEAS;
        end
      end
      BS_MEAS: begin
        if (!meas_en || (low && item_q.now_ms < next_meas)) begin
          st_d = BS_DECIDE;
        end else begin
          meas_d = item_q.now_ms;
          if (!item_q.battery_valid) begin
            lvl_d   = 16'd0;
            known_d = 1'b0;
            st_d    = BS_DECIDE;
          end else begin
            dv_d = 18'($signed({1'b0, cfg_i.sensor_max}) - $signed({1'b0, cfg_i.sensor_min}));
            n_d  = 34'(a_op * b_op);
            st_d = BS_PREP;
          end
        end
      end
      BS_PREP: begin
        neg_d = n_q[33] ^ dv_q[17];
        rem_d = 18'd0;
        cnt_d = 6'd0;
        den_d = {ad, 1'b0};
        if (dv_q == 18'sd0) begin
          div_d = 34'd0;
          neg_d = 1'b0;
          st_d  = BS_FIX;
        end else begin
          div_d = {an[32:0], 1'b0} + 34'(ad);
          st_d  = BS_DIV;
        end
      end
      BS_DIV: begin
        rem_d = ge ? shifted - {1'b0, den_q} : shifted;
        div_d = {div_q[32:0], ge};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_BITS - 1)) st_d = BS_FIX;
      end
      BS_FIX: begin
        if (neg_q) begin
          lvl_d = (div_q > 34'(cfg_i.out_min_mv)) ? 16'd0 : cfg_i.out_min_mv - div_q[15:0];
        end else begin
          lvl_d = (sum > 35'd65535) ? 16'hffff : sum[15:0];
        end
        known_d = 1'b1;
        st_d    = BS_DECIDE;
      end
      BS_DECIDE: begin
        old_d  = src_q;
        ev_d   = EV_NONE;
        sw_d   = 1'b0;
        step_d = 2'd0;
        if (!armed_q || item_q.now_ms > hold_q) begin
          if (item_q.drop) begin
            ev_d    = EV_DROP;
            hold_d  = item_q.now_ms + HOLDOFF_MS;
            armed_d = 1'b1;
            if (src_q == SRC_BATT) begin
              src_d = SRC_PSU;
              sw_d  = 1'b1;
            end else if (src_q == SRC_PSU) begin
              src_d = SRC_BATT;
              sw_d  = 1'b1;
            end
          end else if (cfg_i.mode != MODE_AUTO) begin
            if (cfg_i.mode == MODE_BATT && src_q != SRC_BATT) begin
              src_d = SRC_BATT; ev_d = EV_MAN_BATT; sw_d = 1'b1;
            end else if (cfg_i.mode == MODE_PSU && src_q != SRC_PSU) begin
              src_d = SRC_PSU; ev_d = EV_MAN_PSU; sw_d = 1'b1;
            end
          end else if (charged) begin
            if (src_q != SRC_BATT) begin
              src_d = SRC_BATT; ev_d = EV_AUTO_BATT; sw_d = 1'b1;
            end
          end else if (low) begin
            if (src_q != SRC_PSU) begin
              src_d = SRC_PSU; ev_d = EV_AUTO_PSU; sw_d = 1'b1;
            end
          end
        end
        st_d = BS_OUT;
      end
      BS_OUT: begin
        if (out_ready_i) begin
          if (fin) st_d = BS_IDLE;
          else step_d = step_q + 2'd1;
        end
      end
      default: st_d = BS_IDLE;
    endcase
  end

  // result drives
  always_comb begin
    out_valid_o     = st_q == BS_OUT;
    source_o        = src_q;
    battery_mv_o    = lvl_q;
    battery_known_o = known_q;
    event_res_o     = ev_q;
    last_o          = fin;
    if (fin) begin
      psu_relay_o     = src_q == SRC_PSU;
      battery_relay_o = src_q == SRC_BATT;
      psu_led_o       = src_q != SRC_BATT;
      battery_led_o   = src_q != SRC_PSU;
      wait_after_ms_o = 11'd0;
    end else if (step_q == 2'd0) begin
      psu_relay_o     = 1'b1;
      battery_relay_o = old_q == SRC_BATT;
      psu_led_o       = 1'b1;
      battery_led_o   = old_q != SRC_PSU;
      wait_after_ms_o = WaitMs;
    end else begin
      psu_relay_o     = 1'b1;
      battery_relay_o = 1'b1;
      psu_led_o       = 1'b1;
      battery_led_o   = 1'b1;
      wait_after_ms_o = WaitMs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= BS_IDLE;
      src_q   <= SRC_BOTH;
      lvl_q   <= 16'd0;
      known_q <= 1'b0;
      meas_q  <= 32'd0;
      hold_q  <= 32'd0;
      armed_q <= 1'b0;
      cnt_q   <= 6'd0;
      step_q  <= 2'd0;
      sw_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      src_q   <= src_d;
      lvl_q   <= lvl_d;
      known_q <= known_d;
      meas_q  <= meas_d;
      hold_q  <= hold_d;
      armed_q <= armed_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      sw_q    <= sw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    old_q  <= old_d;
    n_q    <= n_d;
    dv_q   <= dv_d;
    neg_q  <= neg_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    ev_q   <= ev_d;
  end
endmodule
`default_nettype wire

>>> rtl/core/pss_checker.sv
// port-level checks for the power source selector
`timescale 1ns / 1ps
`default_nettype none
`include "power_source_selector_macros.svh"
module pss_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        psu_relay_o,
  input wire logic        psu_led_o,
  input wire logic [10:0] wait_after_ms_o,
  input wire logic [15:0] battery_mv_o,
  input wire logic        battery_known_o,
  input wire logic [2:0]  event_res_o,
  input wire logic        last_o
);
  `PSS_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_ready_i, event_res_o)
  `PSS_ASSERT(a_last_no_wait, clk_i, rst_ni, (out_valid_o && last_o) |-> (wait_after_ms_o == 11'd0))
  `PSS_ASSERT(a_step_psu_on, clk_i, rst_ni, (out_valid_o && !last_o) |-> (psu_relay_o && psu_led_o))
  `PSS_ASSERT(a_unknown_zero, clk_i, rst_ni, (out_valid_o && !battery_known_o) |-> (battery_mv_o == 16'd0))
endmodule

bind power_source_selector pss_checker u_pss_checker (.*);
`default_nettype wire
